// File: hdl/lrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types and constants of the lap record tables block.
// ----------------------------------------------------------------------------
package lrt_pkg;

    localparam int LIST_DEPTH_DEF = 8;
    localparam int DRIVERS_DEF    = 16;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [1:0] TBL_BEST   = 2'd0;
    localparam logic [1:0] TBL_RECENT = 2'd1;
    localparam logic [1:0] TBL_DRIVER = 2'd2;

    typedef struct packed {
        logic [31:0] lap_ms;
        logic [31:0] penalty_ms;
        logic [3:0]  driver;
        logic [7:0]  cone;
        logic [7:0]  off;
    } lap_entry_t;

    typedef struct packed {
        logic [31:0] best_ms;
        logic [31:0] penalty_sum;
        logic [15:0] cone_sum;
        logic [15:0] off_sum;
        logic [15:0] laps;
    } drv_entry_t;

endpackage
`default_nettype wire

// File: hdl/lrt_best_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_best_list
// Ascending best-times list; a zero time marks an empty slot. Insertion
// compares against every slot at once and shifts the tail down by one.
// ----------------------------------------------------------------------------
module lrt_best_list
    import lrt_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire lap_entry_t wr_entry,
    input  wire logic [3:0] rd_idx,
    output lap_entry_t      rd_entry,
    output logic [3:0]      rank
);

    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int RANK_W = $clog2(LIST_DEPTH + 1);

    lap_entry_t            slot_reg  [LIST_DEPTH];
    lap_entry_t            slot_next [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] hit;
    logic [LIST_DEPTH-1:0] take;
    logic [LIST_DEPTH-1:0] shift;
    logic [RANK_W-1:0]     rank_enc;
    logic [31:0]           rank_wide;
    logic [31:0]           idx_wide;

    always_comb
    begin
        logic found;
        found = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            hit[i]   = (slot_reg[i].lap_ms == 32'd0) || (wr_entry.lap_ms < slot_reg[i].lap_ms);
            shift[i] = found;
            take[i]  = hit[i] && !found;
            found    = found || hit[i];
        end
    end

    always_comb
    begin
        rank_enc = RANK_W'(LIST_DEPTH);
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (take[i])
            begin
                rank_enc = RANK_W'(i);
            end
        end
    end

    assign rank_wide = 32'(rank_enc);
    assign rank      = rank_wide[3:0];

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (take[i])
            begin
                slot_next[i] = wr_entry;
            end
            else if (shift[i] && i > 0)
            begin
                slot_next[i] = slot_reg[(i > 0) ? i - 1 : 0];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    assign idx_wide = 32'(rd_idx);
    assign rd_entry = (idx_wide < LIST_DEPTH) ? slot_reg[idx_wide[IDX_W-1:0]] : '0;

endmodule
`default_nettype wire

// File: hdl/lrt_recent_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_recent_list
// Most-recent-first list: each recorded lap enters at the front and the
// oldest entry falls off the end.
// ----------------------------------------------------------------------------
module lrt_recent_list
    import lrt_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire lap_entry_t wr_entry,
    input  wire logic [3:0] rd_idx,
    output lap_entry_t      rd_entry
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    lap_entry_t  slot_reg [LIST_DEPTH];
    logic [31:0] idx_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            slot_reg[0] <= wr_entry;
            for (int i = 1; i < LIST_DEPTH; i++)
            begin
                slot_reg[i] <= slot_reg[i-1];
            end
        end
    end

    assign idx_wide = 32'(rd_idx);
    assign rd_entry = (idx_wide < LIST_DEPTH) ? slot_reg[idx_wide[IDX_W-1:0]] : '0;

endmodule
`default_nettype wire

// File: hdl/lrt_driver_tbl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_driver_tbl
// Per-driver statistics: best time, saturating penalty sum, saturating
// infringement sums and lap count. One address serves both read and update.
// ----------------------------------------------------------------------------
module lrt_driver_tbl
    import lrt_pkg::*;
#(
    parameter int DRIVERS = DRIVERS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       upd_en,
    input  wire logic [3:0] addr,
    input  wire lap_entry_t lap,
    output drv_entry_t      rd_entry
);

    localparam int DRV_W = (DRIVERS > 1) ? $clog2(DRIVERS) : 1;

    drv_entry_t      tbl_reg [DRIVERS];
    drv_entry_t      upd_next;
    logic [31:0]     addr_wide;
    logic [DRV_W-1:0] addr_sel;
    logic            addr_ok;
    logic [32:0]     pen_add;
    logic [16:0]     cone_add;
    logic [16:0]     off_add;

    assign addr_wide = 32'(addr);
    assign addr_sel  = addr_wide[DRV_W-1:0];
    assign addr_ok   = addr_wide < DRIVERS;
    assign rd_entry  = addr_ok ? tbl_reg[addr_sel] : '0;

    assign pen_add  = {1'b0, rd_entry.penalty_sum} + {1'b0, lap.penalty_ms};
    assign cone_add = {1'b0, rd_entry.cone_sum} + {9'd0, lap.cone};
    assign off_add  = {1'b0, rd_entry.off_sum} + {9'd0, lap.off};

    always_comb
    begin
        upd_next = rd_entry;
        if (rd_entry.best_ms == 32'd0 || lap.lap_ms < rd_entry.best_ms)
        begin
            upd_next.best_ms = lap.lap_ms;
        end
        upd_next.penalty_sum = pen_add[32] ? '1 : pen_add[31:0];
        upd_next.cone_sum    = cone_add[16] ? '1 : cone_add[15:0];
        upd_next.off_sum     = off_add[16] ? '1 : off_add[15:0];
        if (rd_entry.laps != 16'hFFFF)
        begin
            upd_next.laps = rd_entry.laps + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DRIVERS; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else if (upd_en && addr_ok)
        begin
            tbl_reg[addr_sel] <= upd_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/lap_record_tables_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lap_record_tables_top
// Best-times list, most-recent list and driver table of finished laps.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one command item: cmd 0 records a
// lap (lap_ms, driver, penalty_ms, cone_hits, off_course), cmd 1 reads entry
// index of table table_sel (0 best, 1 recent, 2 drivers).
// Output channel out_valid/out_stall returns one result item per command:
// the entry read, or for a record only rank (best slot taken, LIST_DEPTH if
// not placed). A record with lap_ms zero changes nothing.
// An accepted item is held in the input register and its result is then
// presented from the result register. Throughput: one item per cycle while the
// output is not stalled; all table updates and reads are done between the
// two registers, so a read sees every earlier record.
// Reset clears all tables and the valid flags of both registers at once;
// items are accepted as soon as reset is released.
// While out_stall is high the result holds; one further item waits in the
// input register, after which in_stall rises.
// ----------------------------------------------------------------------------
module lap_record_tables_top
    import lrt_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int DRIVERS    = DRIVERS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] lap_ms,
    input  wire logic [3:0]  driver,
    input  wire logic [31:0] penalty_ms,
    input  wire logic [7:0]  cone_hits,
    input  wire logic [7:0]  off_course,
    input  wire logic [1:0]  table_sel,
    input  wire logic [3:0]  index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      entry_ms,
    output logic [3:0]       entry_driver,
    output logic [31:0]      entry_penalty,
    output logic [15:0]      entry_cone,
    output logic [15:0]      entry_off,
    output logic [15:0]      entry_laps,
    output logic [3:0]       rank
);

    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    lap_entry_t  s1_lap_reg;
    logic [1:0]  s1_sel_reg;
    logic [3:0]  s1_idx_reg;

    logic        out_valid_reg;
    logic [31:0] entry_ms_reg;
    logic [3:0]  entry_driver_reg;
    logic [31:0] entry_penalty_reg;
    logic [15:0] entry_cone_reg;
    logic [15:0] entry_off_reg;
    logic [15:0] entry_laps_reg;
    logic [3:0]  rank_reg;

    logic        advance;
    logic        in_take;
    logic        rec_en;
    logic        is_record;
    lap_entry_t  best_rd;
    lap_entry_t  recent_rd;
    drv_entry_t  drv_rd;
    logic [3:0]  best_rank;
    logic [3:0]  drv_addr;

    logic [31:0] entry_ms_next;
    logic [3:0]  entry_driver_next;
    logic [31:0] entry_penalty_next;
    logic [15:0] entry_cone_next;
    logic [15:0] entry_off_next;
    logic [15:0] entry_laps_next;
    logic [3:0]  rank_next;
    logic [31:0] depth_wide;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign is_record = (s1_cmd_reg == CMD_RECORD);
    assign rec_en    = advance && is_record && (s1_lap_reg.lap_ms != 32'd0);
    assign drv_addr  = is_record ? s1_lap_reg.driver : s1_idx_reg;

    lrt_best_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (rec_en),
        .wr_entry (s1_lap_reg),
        .rd_idx   (s1_idx_reg),
        .rd_entry (best_rd),
        .rank     (best_rank)
    );

    lrt_recent_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_recent (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (rec_en),
        .wr_entry (s1_lap_reg),
        .rd_idx   (s1_idx_reg),
        .rd_entry (recent_rd)
    );

    lrt_driver_tbl #(
        .DRIVERS (DRIVERS)
    ) u_driver (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd_en   (rec_en),
        .addr     (drv_addr),
        .lap      (s1_lap_reg),
        .rd_entry (drv_rd)
    );

    assign depth_wide = 32'(LIST_DEPTH);

    always_comb
    begin
        entry_ms_next      = '0;
        entry_driver_next  = '0;
        entry_penalty_next = '0;
        entry_cone_next    = '0;
        entry_off_next     = '0;
        entry_laps_next    = '0;
        rank_next          = '0;
        if (is_record)
        begin
            rank_next = (s1_lap_reg.lap_ms != 32'd0) ? best_rank : depth_wide[3:0];
        end
        else
        begin
            case (s1_sel_reg)
                TBL_BEST:
                begin
                    entry_ms_next      = best_rd.lap_ms;
                    entry_driver_next  = best_rd.driver;
                    entry_penalty_next = best_rd.penalty_ms;
                    entry_cone_next    = {8'd0, best_rd.cone};
                    entry_off_next     = {8'd0, best_rd.off};
                end
                TBL_RECENT:
                begin
                    entry_ms_next      = recent_rd.lap_ms;
                    entry_driver_next  = recent_rd.driver;
                    entry_penalty_next = recent_rd.penalty_ms;
                    entry_cone_next    = {8'd0, recent_rd.cone};
                    entry_off_next     = {8'd0, recent_rd.off};
                end
                TBL_DRIVER:
                begin
                    if (32'(s1_idx_reg) < DRIVERS)
                    begin
                        entry_ms_next      = drv_rd.best_ms;
                        entry_driver_next  = s1_idx_reg;
                        entry_penalty_next = drv_rd.penalty_sum;
                        entry_cone_next    = drv_rd.cone_sum;
                        entry_off_next     = drv_rd.off_sum;
                        entry_laps_next    = drv_rd.laps;
                    end
                end
                default:
                begin
                    entry_ms_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg            <= cmd;
            s1_lap_reg.lap_ms     <= lap_ms;
            s1_lap_reg.penalty_ms <= penalty_ms;
            s1_lap_reg.driver     <= driver;
            s1_lap_reg.cone       <= cone_hits;
            s1_lap_reg.off        <= off_course;
            s1_sel_reg            <= table_sel;
            s1_idx_reg            <= index;
        end
        if (advance)
        begin
            entry_ms_reg      <= entry_ms_next;
            entry_driver_reg  <= entry_driver_next;
            entry_penalty_reg <= entry_penalty_next;
            entry_cone_reg    <= entry_cone_next;
            entry_off_reg     <= entry_off_next;
            entry_laps_reg    <= entry_laps_next;
            rank_reg          <= rank_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_ms      = entry_ms_reg;
    assign entry_driver  = entry_driver_reg;
    assign entry_penalty = entry_penalty_reg;
    assign entry_cone    = entry_cone_reg;
    assign entry_off     = entry_off_reg;
    assign entry_laps    = entry_laps_reg;
    assign rank          = rank_reg;

endmodule
`default_nettype wire

// File: bench/lap_tables_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lap_tables_checker
// Watches both channels of lap_record_tables_top and checks every answer.
// ----------------------------------------------------------------------------
// Keeps its own copy of the best-times list, the most-recent list and the
// driver table. It updates them for each accepted command item and queues the
// answer that item should give. Each accepted result item is compared field
// by field with the oldest queued answer. Mismatches and the number of
// answers still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module lap_tables_checker
    import lrt_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int DRIVERS    = DRIVERS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] lap_ms,
    input  wire logic [3:0]  driver,
    input  wire logic [31:0] penalty_ms,
    input  wire logic [7:0]  cone_hits,
    input  wire logic [7:0]  off_course,
    input  wire logic [1:0]  table_sel,
    input  wire logic [3:0]  index,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] entry_ms,
    input  wire logic [3:0]  entry_driver,
    input  wire logic [31:0] entry_penalty,
    input  wire logic [15:0] entry_cone,
    input  wire logic [15:0] entry_off,
    input  wire logic [15:0] entry_laps,
    input  wire logic [3:0]  rank,
    output int               mismatches,
    output int               pending
);

    typedef struct packed {
        logic [31:0] ms;
        logic [3:0]  drv;
        logic [31:0] pen;
        logic [15:0] cone;
        logic [15:0] off;
        logic [15:0] laps;
        logic [3:0]  rank;
    } table_answer_t;

    lap_entry_t    best_list   [LIST_DEPTH];
    lap_entry_t    recent_list [LIST_DEPTH];
    drv_entry_t    drv_table   [DRIVERS];
    table_answer_t predicted_answers [$];

    task automatic clear_tables();
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            best_list[i]   = '0;
            recent_list[i] = '0;
        end
        for (int i = 0; i < DRIVERS; i++)
            drv_table[i] = '0;
    endtask

    function automatic logic [15:0] sat_count(logic [15:0] sum, logic [15:0] add);
        logic [16:0] s;
        s = {1'b0, sum} + {1'b0, add};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // update the tables for one command item and return its answer
    function automatic table_answer_t apply_command();
        table_answer_t ans;
        lap_entry_t    lap;
        int            slot;
        logic [32:0]   psum;
        ans  = '0;
        slot = LIST_DEPTH;
        if (cmd == CMD_RECORD)
        begin
            if (lap_ms != 0)
            begin
                lap.lap_ms     = lap_ms;
                lap.penalty_ms = penalty_ms;
                lap.driver     = driver;
                lap.cone       = cone_hits;
                lap.off        = off_course;
                for (int i = 0; i < LIST_DEPTH; i++)
                    if (slot == LIST_DEPTH &&
                        (best_list[i].lap_ms == 0 || lap_ms < best_list[i].lap_ms))
                        slot = i;
                if (slot < LIST_DEPTH)
                begin
                    for (int j = LIST_DEPTH - 1; j > slot; j--)
                        best_list[j] = best_list[j - 1];
                    best_list[slot] = lap;
                end
                for (int j = LIST_DEPTH - 1; j > 0; j--)
                    recent_list[j] = recent_list[j - 1];
                recent_list[0] = lap;
                if (driver < DRIVERS)
                begin
                    if (drv_table[driver].best_ms == 0 || lap_ms < drv_table[driver].best_ms)
                        drv_table[driver].best_ms = lap_ms;
                    psum = {1'b0, drv_table[driver].penalty_sum} + {1'b0, penalty_ms};
                    drv_table[driver].penalty_sum = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
                    drv_table[driver].cone_sum =
                        sat_count(drv_table[driver].cone_sum, {8'd0, cone_hits});
                    drv_table[driver].off_sum =
                        sat_count(drv_table[driver].off_sum, {8'd0, off_course});
                    drv_table[driver].laps = sat_count(drv_table[driver].laps, 16'd1);
                end
            end
            ans.rank = slot[3:0];
        end
        else if ((table_sel == TBL_BEST || table_sel == TBL_RECENT) && index < LIST_DEPTH)
        begin
            lap      = (table_sel == TBL_BEST) ? best_list[index] : recent_list[index];
            ans.ms   = lap.lap_ms;
            ans.drv  = lap.driver;
            ans.pen  = lap.penalty_ms;
            ans.cone = {8'd0, lap.cone};
            ans.off  = {8'd0, lap.off};
        end
        else if (table_sel == TBL_DRIVER && index < DRIVERS)
        begin
            ans.ms   = drv_table[index].best_ms;
            ans.drv  = index;
            ans.pen  = drv_table[index].penalty_sum;
            ans.cone = drv_table[index].cone_sum;
            ans.off  = drv_table[index].off_sum;
            ans.laps = drv_table[index].laps;
        end
        return ans;
    endfunction

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t ans;
        if (!rst_n)
        begin
            clear_tables();
            predicted_answers.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_answers.size() == 0)
                begin
                    $display("%0t: result item with no answer due, got ms %h rank %h",
                             $time, entry_ms, rank);
                    mismatches++;
                end
                else
                begin
                    ans = predicted_answers.pop_front();
                    check_field("entry_ms",      ans.ms,          entry_ms);
                    check_field("entry_driver",  32'(ans.drv),    32'(entry_driver));
                    check_field("entry_penalty", ans.pen,         entry_penalty);
                    check_field("entry_cone",    32'(ans.cone),   32'(entry_cone));
                    check_field("entry_off",     32'(ans.off),    32'(entry_off));
                    check_field("entry_laps",    32'(ans.laps),   32'(entry_laps));
                    check_field("rank",          32'(ans.rank),   32'(rank));
                end
            end
            if (in_valid && !in_stall)
                predicted_answers.push_back(apply_command());
            pending = predicted_answers.size();
        end
    end

endmodule
`default_nettype wire

// File: bench/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Regression of lap_record_tables_top against a predicting checker.
// ----------------------------------------------------------------------------
// A short directed run covers empty tables, extreme fields, equal times, a
// dropped lap, zero lap time, the unused selector and reads out of range.
// Random records and reads follow, with laps that mostly get faster so the
// best list keeps changing. A burst on one driver drives its penalty and
// infringement sums into saturation. Both sides idle at random but for two
// quiet stretches; the block drains fully twice. The checker counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import lrt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [31:0] lap_ms;
    logic [3:0]  driver;
    logic [31:0] penalty_ms;
    logic [7:0]  cone_hits;
    logic [7:0]  off_course;
    logic [1:0]  table_sel;
    logic [3:0]  index;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] entry_ms;
    logic [3:0]  entry_driver;
    logic [31:0] entry_penalty;
    logic [15:0] entry_cone;
    logic [15:0] entry_off;
    logic [15:0] entry_laps;
    logic [3:0]  rank;
    int          mismatches;
    int          pending;
    bit          quiet;

    lap_record_tables_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .lap_ms        (lap_ms),
        .driver        (driver),
        .penalty_ms    (penalty_ms),
        .cone_hits     (cone_hits),
        .off_course    (off_course),
        .table_sel     (table_sel),
        .index         (index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .entry_ms      (entry_ms),
        .entry_driver  (entry_driver),
        .entry_penalty (entry_penalty),
        .entry_cone    (entry_cone),
        .entry_off     (entry_off),
        .entry_laps    (entry_laps),
        .rank          (rank)
    );

    lap_tables_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .lap_ms        (lap_ms),
        .driver        (driver),
        .penalty_ms    (penalty_ms),
        .cone_hits     (cone_hits),
        .off_course    (off_course),
        .table_sel     (table_sel),
        .index         (index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .entry_ms      (entry_ms),
        .entry_driver  (entry_driver),
        .entry_penalty (entry_penalty),
        .entry_cone    (entry_cone),
        .entry_off     (entry_off),
        .entry_laps    (entry_laps),
        .rank          (rank),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("lap_record_tables_top regression: fail");
        $finish;
    end

    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 29);

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic c, logic [31:0] lap, logic [3:0] drv, logic [31:0] pen,
                             logic [7:0] cone, logic [7:0] off, logic [1:0] sel,
                             logic [3:0] idx);
        while (!quiet && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        lap_ms     <= lap;
        driver     <= drv;
        penalty_ms <= pen;
        cone_hits  <= cone;
        off_course <= off;
        table_sel  <= sel;
        index      <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic record_lap(logic [31:0] lap, logic [3:0] drv, logic [31:0] pen,
                              logic [7:0] cone, logic [7:0] off);
        send_item(CMD_RECORD, lap, drv, pen, cone, off, 2'($urandom_range(0, 3)),
                  4'($urandom_range(0, 15)));
    endtask

    task automatic read_entry(logic [1:0] sel, logic [3:0] idx);
        send_item(CMD_READ, $urandom, 4'($urandom_range(0, 15)), $urandom,
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sel, idx);
    endtask

    task automatic drain_answers();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] lap;
        logic [31:0] pen;
        int          pick;
        int          trend;

        rst_n      = 1'b0;
        quiet      = 1'b0;
        in_valid   = 1'b0;
        out_stall  = 1'b0;
        cmd        = CMD_RECORD;
        lap_ms     = '0;
        driver     = '0;
        penalty_ms = '0;
        cone_hits  = '0;
        off_course = '0;
        table_sel  = TBL_BEST;
        index      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty tables
        read_entry(TBL_BEST, 4'd0);
        read_entry(TBL_RECENT, 4'd7);
        read_entry(TBL_DRIVER, 4'd15);
        // extremes, equal times, zero lap
        record_lap(32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        record_lap(32'd1, 4'd0, 32'd0, 8'd0, 8'd0);
        record_lap(32'd1, 4'd3, 32'd7, 8'd1, 8'd2);
        record_lap(32'd0, 4'd5, 32'd9, 8'd3, 8'd4);
        for (int i = 0; i < 8; i++)
            record_lap(32'd100 + i, 4'(i), 32'd10 * i, 8'(i), 8'(8 - i));
        // slower than a full list
        record_lap(32'd200, 4'd6, 32'd1, 8'd1, 8'd1);
        read_entry(TBL_BEST, 4'd1);
        read_entry(TBL_BEST, 4'd7);
        read_entry(TBL_RECENT, 4'd0);
        read_entry(TBL_DRIVER, 4'd0);
        read_entry(2'd3, 4'd2);
        read_entry(TBL_BEST, 4'd8);
        read_entry(TBL_RECENT, 4'd15);
        read_entry(TBL_DRIVER, 4'd5);

        for (int n = 0; n < 1700; n++)
        begin
            if (n == 700)
                quiet = 1'b1;
            if (n == 1000)
                quiet = 1'b0;
            if (n == 1300)
                drain_answers();
            if ($urandom_range(0, 99) < 55)
            begin
                pick  = $urandom_range(0, 99);
                trend = 2500 - n + $urandom_range(0, 40);
                if (pick < 60)
                    lap = trend;
                else if (pick < 75)
                    lap = $urandom;
                else if (pick < 80)
                    lap = 32'hFFFF_FFFF;
                else if (pick < 85)
                    lap = 32'd0;
                else
                    lap = $urandom_range(1, 20);
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    pen = $urandom_range(0, 5000);
                else if (pick < 80)
                    pen = $urandom;
                else if (pick < 90)
                    pen = 32'd0;
                else
                    pen = 32'hFFFF_FFFF;
                record_lap(lap, 4'($urandom_range(0, 15)), pen,
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            else
                read_entry(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        end

        // saturate the penalty and infringement sums of one driver
        quiet = 1'b1;
        for (int k = 0; k < 300; k++)
        begin
            record_lap($urandom_range(1000, 100000), 4'd9, $urandom | 32'h8000_0000,
                       8'hFF, 8'hFF);
            if (k % 64 == 0)
                read_entry(TBL_DRIVER, 4'd9);
        end
        read_entry(TBL_DRIVER, 4'd9);
        quiet = 1'b0;
        read_entry(TBL_RECENT, 4'd0);
        read_entry(TBL_BEST, 4'd0);

        drain_answers();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("lap_record_tables_top regression: pass");
        else
            $display("lap_record_tables_top regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
hdl/lrt_pkg.sv
hdl/lrt_best_list.sv
hdl/lrt_recent_list.sv
hdl/lrt_driver_tbl.sv
hdl/lap_record_tables_top.sv
bench/lap_tables_checker.sv
bench/testbench.sv
